// File: design/bit_pattern_bind_parity_macros.svh
// assertion helpers used by the rtl file bpbp_scan.sv
`ifndef BIT_PATTERN_BIND_PARITY_MACROS_SVH
`define BIT_PATTERN_BIND_PARITY_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BPBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpbp assertion failed");
// antecedent implies consequent in the next cycle
`define BPBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpbp assertion failed");
`else
`define BPBP_ASSERT_NOW(label, ante, cons)
`define BPBP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/bpbp_pkg.sv
package bpbp_pkg;

  localparam int unsigned PATTERN_W   = 16;
  localparam int unsigned PLEN_W      = 5;
  localparam int unsigned GENE_W      = 64;
  localparam int unsigned GLEN_W      = 7;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GENE_BITS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GENE_LENGTH = 1'b1;

  localparam logic [GLEN_W-1:0] GENE_LENGTH_RST = 7'd64;

  typedef struct packed {
    logic start;
    logic clear;
    logic hold;
  } scan_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scan_status_t;

endpackage

// File: design/bpbp_scan.sv
`include "bit_pattern_bind_parity_macros.svh"

module bpbp_scan #(
  parameter int unsigned GENE_BITS    = 64,
  parameter int unsigned PATTERN_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bpbp_pkg::scan_cmd_t                 cmd,
  input  logic [bpbp_pkg::PATTERN_W-1:0]      pattern,
  input  logic [bpbp_pkg::PLEN_W-1:0]         plen,
  input  logic [bpbp_pkg::GENE_W-1:0]         gene,
  input  logic [bpbp_pkg::GLEN_W-1:0]         gene_len,
  output bpbp_pkg::scan_status_t              status,
  output logic [GENE_BITS-1:0]                occ_final,
  output logic                                active_final
);

  localparam int unsigned LW  = $clog2(GENE_BITS + 1);
  localparam int unsigned PLW = $clog2(PATTERN_BITS + 1);
  localparam logic [LW-1:0] LAST = LW'(GENE_BITS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                    state_r, state_nxt;
  logic [LW-1:0]           off_r, off_nxt;
  logic [GENE_BITS-1:0]    gene_sh_r, gene_sh_nxt;
  logic [GENE_BITS-1:0]    occ_r, occ_nxt;
  logic [PATTERN_BITS-1:0] pat_r, pat_nxt;
  logic [PATTERN_BITS-1:0] pmask_r, pmask_nxt;
  logic [PLW-1:0]          plen_r, plen_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic                    bind_r, bind_nxt;
  logic                    par_r, par_nxt;

  logic [bpbp_pkg::GLEN_W-1:0]          plen7, len7;
  logic [PATTERN_BITS-1:0]              pmask_w, pat_w;
  logic [PATTERN_BITS+bpbp_pkg::PATTERN_W-1:0] pat_ext;
  logic [GENE_BITS+PATTERN_BITS-1:0]    gene_ext, occ_ext;
  logic [PATTERN_BITS-1:0]              window, flip;
  logic [GENE_BITS-1:0]                 occ_mod, occ_rot;
  logic                                 hit, in_use, last, advance, par_step;

  // item setup: clamp lengths, build the pattern mask
  always_comb begin
    plen7 = ({2'b00, plen} > 7'(PATTERN_BITS)) ? 7'(PATTERN_BITS) : {2'b00, plen};
    len7  = (gene_len > 7'(GENE_BITS)) ? 7'(GENE_BITS) : gene_len;
    for (int i = 0; i < PATTERN_BITS; i++) begin
      pmask_w[i] = (7'(i) < plen7);
    end
    pat_ext = {{PATTERN_BITS{1'b0}}, pattern};
    pat_w   = pat_ext[PATTERN_BITS-1:0] & pmask_w;
  end

  // one offset per cycle unless held at the last offset: low bits of the shifted sequence form the window
  always_comb begin
    last     = (off_r == LAST);
    gene_ext = {{PATTERN_BITS{1'b0}}, gene_sh_r};
    window   = gene_ext[PATTERN_BITS-1:0] & pmask_r;
    hit      = bind_r && (window == pat_r)
               && ((8'(off_r) + 8'(plen_r)) <= 8'(len_r));
    flip     = hit ? pmask_r : '0;
    occ_ext  = {{PATTERN_BITS{1'b0}}, occ_r} ^ {{GENE_BITS{1'b0}}, flip};
    occ_mod  = occ_ext[GENE_BITS-1:0];
    occ_rot  = (occ_mod >> 1) | (occ_mod << (GENE_BITS - 1));
    // position off is final once its own offset is done
    in_use   = (off_r < len_r);
    par_step = par_r ^ (in_use & gene_sh_r[0] & ~occ_mod[0]);
    advance  = (state_r == ST_RUN) && (!last || !cmd.hold);
  end

  always_comb begin
    state_nxt   = state_r;
    off_nxt     = off_r;
    gene_sh_nxt = gene_sh_r;
    occ_nxt     = occ_r;
    pat_nxt     = pat_r;
    pmask_nxt   = pmask_r;
    plen_nxt    = plen_r;
    len_nxt     = len_r;
    bind_nxt    = bind_r;
    par_nxt     = par_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt   = ST_RUN;
          off_nxt     = '0;
          gene_sh_nxt = gene[GENE_BITS-1:0];
          occ_nxt     = cmd.clear ? '0 : occ_r;
          pat_nxt     = pat_w;
          pmask_nxt   = pmask_w;
          plen_nxt    = plen7[PLW-1:0];
          len_nxt     = len7[LW-1:0];
          bind_nxt    = !cmd.clear && (plen7 != '0);
          par_nxt     = 1'b0;
        end
      end
      ST_RUN: begin
        if (advance) begin
          gene_sh_nxt = gene_sh_r >> 1;
          occ_nxt     = occ_rot;
          par_nxt     = par_step;
          if (last) begin
            state_nxt = ST_IDLE;
            off_nxt   = '0;
          end else begin
            off_nxt = off_r + LW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      off_r   <= '0;
      occ_r   <= '0;
      bind_r  <= 1'b0;
      par_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      off_r   <= off_nxt;
      occ_r   <= occ_nxt;
      bind_r  <= bind_nxt;
      par_r   <= par_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gene_sh_r <= gene_sh_nxt;
    pat_r     <= pat_nxt;
    pmask_r   <= pmask_nxt;
    plen_r    <= plen_nxt;
    len_r     <= len_nxt;
  end

  assign status.busy  = (state_r == ST_RUN);
  assign status.done  = advance && last;
  assign occ_final    = occ_rot;
  assign active_final = par_step;

  `BPBP_ASSERT_NEXT(a_start_runs, (state_r == ST_IDLE) && cmd.start, status.busy && (off_r == '0))
  `BPBP_ASSERT_NOW(a_idle_off_zero, !status.busy, off_r == '0)
  `BPBP_ASSERT_NEXT(a_stall_keeps_mask, status.busy && last && cmd.hold, $stable(occ_r) && status.busy)
  `BPBP_ASSERT_NOW(a_no_flip_on_clear, status.busy && !bind_r, flip == '0)

endmodule

// File: design/bit_pattern_bind_parity.sv
// channel  | handshake                 | payload
// in_      | in_tvalid / in_tready     | tdata: pattern_bits, pattern_length; tuser: action
// out_     | out_tvalid / out_tready   | tdata: occupancy, active
// cfg_     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// each item scans all GENE_BITS sequence offsets, one per cycle unless held at the last,
// starting the cycle after its accept edge; out_tvalid rises at the edge of the last offset
// in_tready is high only while the scan is idle, so no item is taken while one is scanning
// a held result does not block the next accept
// if the output register is still full at the last offset, the scan waits there
// rst_n is synchronous: mask cleared, gene_bits 0, gene_length 64

module bit_pattern_bind_parity #(
  parameter int unsigned GENE_BITS    = 64,
  parameter int unsigned PATTERN_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [15:0] pattern_bits, [20:16] pattern_length, [23:21] zero
  input  logic [bpbp_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [0] action
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [63:0] occupancy, [64] active, [71:65] zero
  output logic [bpbp_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bpbp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bpbp_pkg::GENE_W-1:0]           cfg_data
);

  logic [bpbp_pkg::GENE_W-1:0] gene_bits_r;
  logic [bpbp_pkg::GLEN_W-1:0] gene_length_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [bpbp_pkg::GENE_W-1:0] occ_out_r;
  logic                        active_out_r;

  bpbp_pkg::scan_cmd_t    cmd;
  bpbp_pkg::scan_status_t status;
  logic [GENE_BITS-1:0]   occ_final;
  logic                   active_final;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gene_bits_r   <= '0;
      gene_length_r <= bpbp_pkg::GENE_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bpbp_pkg::REG_GENE_BITS:   gene_bits_r   <= cfg_data;
        bpbp_pkg::REG_GENE_LENGTH: gene_length_r <= cfg_data[bpbp_pkg::GLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !status.busy;
  assign cmd.start = in_tvalid && in_tready;
  assign cmd.clear = in_tuser;
  assign cmd.hold  = out_valid_r && !out_tready;

  bpbp_scan #(
    .GENE_BITS    (GENE_BITS),
    .PATTERN_BITS (PATTERN_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .pattern      (in_tdata[bpbp_pkg::PATTERN_W-1:0]),
    .plen         (in_tdata[bpbp_pkg::PATTERN_W +: bpbp_pkg::PLEN_W]),
    .gene         (gene_bits_r),
    .gene_len     (gene_length_r),
    .status       (status),
    .occ_final    (occ_final),
    .active_final (active_final)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (status.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      occ_out_r    <= (bpbp_pkg::GENE_W)'(occ_final);
      active_out_r <= active_final;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bpbp_pkg::OUT_TDATA_W - bpbp_pkg::GENE_W - 1){1'b0}},
                       active_out_r, occ_out_r};

endmodule

// File: bench/tb_top.sv
module tb_top;
  import bpbp_pkg::*;

  typedef struct packed {
    logic                 clear;
    logic [PATTERN_W-1:0] pattern;
    logic [PLEN_W-1:0]    plen;
  } bind_cmd_t;

  typedef struct packed {
    logic [GENE_W-1:0] occupancy;
    logic              active;
  } mask_state_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [15:0] pattern_bits, [20:16] pattern_length, [23:21] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [0] action
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [63:0] occupancy, [64] active, [71:65] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [GENE_W-1:0]      cfg_data;

  bit_pattern_bind_parity DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the block's registers and occupancy
  logic [GENE_W-1:0] gene_shadow;
  logic [GLEN_W-1:0] glen_shadow;
  logic [GENE_W-1:0] occ_shadow;

  bind_cmd_t   pending_cmds[$];
  mask_state_t expected_masks[$];

  bit in_taken;
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int masks_checked;
  int clears_seen;
  int matched_binds;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("timeout at %0t with %0d results outstanding", $time, expected_masks.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int used_positions();
    return (glen_shadow > GENE_W) ? GENE_W : int'(glen_shadow);
  endfunction

  // applies one command to the occupancy shadow and returns what the block must report
  function automatic mask_state_t predict_occupancy(bind_cmd_t cmd);
    mask_state_t res;
    int used;
    int plen_e;
    int off;
    bit hit;
    logic [GENE_W-1:0] pmask;
    logic [GENE_W-1:0] pat;
    logic [GENE_W-1:0] in_use;
    used = used_positions();
    plen_e = (cmd.plen > PATTERN_W) ? PATTERN_W : int'(cmd.plen);
    hit = 1'b0;
    if (cmd.clear) begin
      occ_shadow = '0;
      clears_seen++;
    end else if (plen_e != 0 && plen_e <= used) begin
      pmask = (64'd1 << plen_e) - 64'd1;
      pat = {{(GENE_W-PATTERN_W){1'b0}}, cmd.pattern} & pmask;
      for (off = 0; off + plen_e <= used; off++) begin
        if (((gene_shadow >> off) & pmask) == pat) begin
          occ_shadow ^= pmask << off;
          hit = 1'b1;
        end
      end
    end
    if (hit) matched_binds++;
    in_use = (used >= GENE_W) ? '1 : ((64'd1 << used) - 64'd1);
    res.occupancy = occ_shadow;
    res.active = ^(gene_shadow & ~occ_shadow & in_use);
    return res;
  endfunction

  // pattern copied out of the sequence at a random offset, junk above its length
  function automatic logic [PATTERN_W-1:0] lifted_pattern(int plen);
    int used;
    int plen_e;
    int off;
    logic [PATTERN_W-1:0] pmask;
    logic [GENE_W-1:0] window;
    used = used_positions();
    plen_e = (plen > PATTERN_W) ? PATTERN_W : plen;
    if (plen_e == 0 || plen_e > used) return PATTERN_W'($urandom);
    off = $urandom_range(used - plen_e);
    pmask = (16'd1 << plen_e) - 16'd1;
    if (plen_e == PATTERN_W) pmask = '1;
    window = gene_shadow >> off;
    return (PATTERN_W'($urandom) & ~pmask) | (window[PATTERN_W-1:0] & pmask);
  endfunction

  function automatic void queue_cmd(logic clear, logic [PATTERN_W-1:0] pattern,
                                    logic [PLEN_W-1:0] plen);
    bind_cmd_t cmd;
    cmd.clear = clear;
    cmd.pattern = pattern;
    cmd.plen = plen;
    pending_cmds.push_back(cmd);
  endfunction

  function automatic void queue_random_cmd();
    int pick;
    int plen;
    pick = $urandom_range(99);
    if (pick < 10) begin
      queue_cmd(1'b1, PATTERN_W'($urandom), PLEN_W'($urandom));
    end else if (pick < 65) begin
      // mostly short patterns so that offsets overlap and flip each other back
      plen = ($urandom_range(3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      queue_cmd(1'b0, lifted_pattern(plen), PLEN_W'(plen));
    end else if (pick < 80) begin
      queue_cmd(1'b0, PATTERN_W'($urandom), PLEN_W'($urandom_range(1, 4)));
    end else begin
      queue_cmd(1'b0, PATTERN_W'($urandom), PLEN_W'($urandom));
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GENE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // holds the sender back until every result in flight has come out
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_tvalid || expected_masks.size() != 0)
      @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bind_cmd_t cmd;
          cmd = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {3'b000, cmd.plen, cmd.pattern};
          in_tuser  <= cmd.clear;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: register shadow, prediction on accepted beats, result compare
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
      gene_shadow = '0;
      glen_shadow = GENE_LENGTH_RST;
      occ_shadow = '0;
    end else begin
      in_taken = in_tvalid && in_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GENE_BITS:   gene_shadow = cfg_data;
          REG_GENE_LENGTH: glen_shadow = cfg_data[GLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_taken)
        expected_masks.push_back(predict_occupancy({in_tuser, in_tdata[15:0], in_tdata[20:16]}));
      if (out_tvalid && out_tready) begin
        if (expected_masks.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
        end else begin
          mask_state_t want;
          want = expected_masks.pop_front();
          masks_checked++;
          if (out_tdata[63:0] !== want.occupancy) begin
            mismatches++;
            $display("%0t: occupancy expected %h actual %h", $time, want.occupancy,
                     out_tdata[63:0]);
          end
          if (out_tdata[64] !== want.active) begin
            mismatches++;
            $display("%0t: active expected %b actual %b", $time, want.active, out_tdata[64]);
          end
        end
      end
    end
  end

  initial begin
    int phase;
    int n;
    logic [GENE_W-1:0] gene;
    logic [GLEN_W-1:0] glen;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_GENE_BITS;
    cfg_data = '0;
    send_idle_pct = 37;
    recv_idle_pct = 83;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset sequence is all zeros over 64 positions
    queue_cmd(1'b0, 16'h0000, 5'd1);   // every offset matches
    queue_cmd(1'b0, 16'h0000, 5'd16);  // overlapping matches
    queue_cmd(1'b0, 16'hffff, 5'd16);  // no match anywhere
    queue_cmd(1'b0, 16'h1234, 5'd0);   // empty pattern
    queue_cmd(1'b0, 16'h0000, 5'd31);  // length clamps to 16
    queue_cmd(1'b1, 16'hffff, 5'd31);
    wait_idle();
    write_reg(REG_GENE_BITS, '1);
    queue_cmd(1'b0, 16'hffff, 5'd16);
    queue_cmd(1'b0, 16'hfffe, 5'd17);
    queue_cmd(1'b0, 16'h0001, 5'd1);
    wait_idle();
    // no positions in use
    write_reg(REG_GENE_LENGTH, 64'd0);
    queue_cmd(1'b0, 16'h0001, 5'd1);
    queue_cmd(1'b0, 16'h0000, 5'd1);
    wait_idle();
    write_reg(REG_GENE_BITS, {$urandom, $urandom});
    write_reg(REG_GENE_LENGTH, 64'd127);
    queue_cmd(1'b0, lifted_pattern(16), 5'd16);
    queue_cmd(1'b0, lifted_pattern(5), 5'd5);
    wait_idle();
    // pattern longer than the used sequence, then one that fits exactly
    write_reg(REG_GENE_LENGTH, 64'd10);
    queue_cmd(1'b0, PATTERN_W'($urandom), 5'd12);
    queue_cmd(1'b0, lifted_pattern(10), 5'd10);
    wait_idle();
    // grow the sequence under existing occupancy
    write_reg(REG_GENE_LENGTH, 64'd64);
    queue_cmd(1'b0, lifted_pattern(3), 5'd3);
    queue_cmd(1'b0, lifted_pattern(2), 5'd2);
    wait_idle();
    write_reg(REG_GENE_LENGTH, 64'd8);
    queue_cmd(1'b0, 16'h0000, 5'd0);
    queue_cmd(1'b1, 16'h0000, 5'd0);
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 83;
        recv_idle_pct = 37;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      gene = {$urandom, $urandom};
      case (phase)
        0: glen = 7'd64;
        1: begin gene = '1; glen = 7'd64; end
        2: glen = 7'd1;
        3: begin gene = '0; glen = 7'd127; end
        4: begin gene = {16{4'b1100}}; glen = GLEN_W'($urandom_range(17, 63)); end
        5: glen = 7'd0;
        6: glen = GLEN_W'($urandom_range(0, 127));
        default: begin gene = gene & {$urandom, $urandom} & {$urandom, $urandom}; glen = 7'd40; end
      endcase
      write_reg(REG_GENE_BITS, gene);
      write_reg(REG_GENE_LENGTH, {{(GENE_W-GLEN_W){1'b0}}, glen});
      for (n = 0; n < 200; n++) queue_random_cmd();
      wait_idle();
    end

    repeat (80) @(negedge clk);
    $display("checked %0d results: %0d clears, %0d binds with at least one match",
             masks_checked, clears_seen, matched_binds);
    $display("%0d register writes, sequence lengths from 0 to 127, three idle mixes",
             reg_writes);
    if (mismatches == 0 && expected_masks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/bpbp_pkg.sv
design/bpbp_scan.sv
design/bit_pattern_bind_parity.sv
bench/tb_top.sv
